// File: rtl/core/tar_stream_unpacker_core_assert.svh
// Assertion macros used by the unpacker core RTL.
`ifndef TAR_STREAM_UNPACKER_CORE_ASSERT_SVH
`define TAR_STREAM_UNPACKER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TSU_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("unpacker assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define TSU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("unpacker assertion failed");

`endif

// File: rtl/core/tarsu_pkg.sv
`default_nettype none

package tarsu_pkg;

    // Kind of one result transfer.
    typedef enum logic [2:0] {
        KIND_NAME       = 3'd0,
        KIND_DATA       = 3'd1,
        KIND_ACCEPT     = 3'd2,
        KIND_END        = 3'd3,
        KIND_NESTED     = 3'd4,
        KIND_BAD_MAGIC  = 3'd5
    } kind_t;

    typedef struct packed {
        kind_t       out_kind;
        logic [7:0]  out_byte;
        logic [6:0]  name_pos;
        logic [31:0] file_size;
        logic        last_of_file;
    } result_t;

endpackage

`default_nettype wire

// File: rtl/core/tarsu_stream_if.sv
`default_nettype none

// Byte channel carrying the raw archive stream.
interface tarsu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

// Result channel carrying name bytes, data bytes and header verdicts.
interface tarsu_out_if;
    logic              valid;
    logic              ready;
    tarsu_pkg::kind_t  out_kind;
    logic [7:0]        out_byte;
    logic [6:0]        name_pos;
    logic [31:0]       file_size;
    logic              last_of_file;

    modport source (output valid, output out_kind, output out_byte, output name_pos,
                    output file_size, output last_of_file, input ready);
    modport sink   (input valid, input out_kind, input out_byte, input name_pos,
                    input file_size, input last_of_file, output ready);
endinterface

`default_nettype wire

// File: rtl/core/tarsu_out_buf.sv
`default_nettype none

// Two-entry result buffer. It decouples the parser from a stalling receiver
// so that a full-rate stream keeps flowing.
module tarsu_out_buf (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  tarsu_pkg::result_t push_data,
    output logic               space,
    tarsu_out_if.source        result
);

    tarsu_pkg::result_t entry_reg [2];
    logic               wr_ptr_reg;
    logic               wr_ptr_next;
    logic               rd_ptr_reg;
    logic               rd_ptr_next;
    logic [1:0]         count_reg;
    logic [1:0]         count_next;
    logic               pop;
    tarsu_pkg::result_t head;

    assign pop   = result.valid && result.ready;
    assign space = (count_reg != 2'd2) || pop;
    assign head  = entry_reg[rd_ptr_reg];

    assign result.valid        = count_reg != 2'd0;
    assign result.out_kind     = head.out_kind;
    assign result.out_byte     = head.out_byte;
    assign result.name_pos     = head.name_pos;
    assign result.file_size    = head.file_size;
    assign result.last_of_file = head.last_of_file;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/tar_stream_unpacker_core.sv
// Streaming ustar archive unpacker.
// The archive channel takes one raw byte per transfer; the stream is cut into
// 512-byte blocks. In a header block the 100 name bytes come out as name
// transfers with their offset, and the last byte of the block yields one
// verdict: end block, bad magic, nested ".tar" skipped, or header accepted
// with the parsed octal size. In a file block the data bytes come out until
// the size is used up, the final one marked last_of_file; padding is dropped.
// A bad magic leaves the block in a sticky error state in which bytes are
// still taken but nothing comes out until reset.
// An archive byte is first registered in the input register; the parse logic
// behind it then writes its result into the result buffer, from which the
// result is offered to the receiver. Throughput is one byte per cycle while
// the buffer can take a result, set by the single parse stage between the
// input register and the two-entry result buffer.
// Reset returns to header parsing at block offset zero and empties both the
// input register and the result buffer. When the receiver stalls, results
// collect in the buffer; once it holds two, the parse stage holds its byte and
// the archive channel drops ready until a result transfer frees an entry.
`default_nettype none

`include "tar_stream_unpacker_core_assert.svh"

module tar_stream_unpacker_core #(
    parameter int unsigned SIZE_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    tarsu_in_if.sink    archive,
    tarsu_out_if.source result
);

    localparam logic [8:0]  SIZE_FIRST  = 9'd124;
    localparam logic [8:0]  SIZE_LAST   = 9'd135;
    localparam logic [8:0]  MAGIC_FIRST = 9'd257;
    localparam logic [8:0]  MAGIC_LAST  = 9'd261;
    localparam logic [8:0]  LAST_POS    = 9'd511;
    localparam logic [8:0]  NAME_BYTES  = 9'd100;
    localparam logic [6:0]  NAME_MAX    = 7'd100;
    localparam logic [31:0] TAR_SUFFIX  = 32'h2E746172;

    typedef enum logic [1:0] {
        MODE_HEADER = 2'd0,
        MODE_FILE   = 2'd1,
        MODE_ERROR  = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        PH_BLANKS = 2'd0,
        PH_DIGITS = 2'd1,
        PH_DONE   = 2'd2
    } phase_t;

    // Expected "ustar" characters by offset within the magic field.
    function automatic logic [7:0] magic_char(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = 8'h75;
            3'd1:    ch = 8'h73;
            3'd2:    ch = 8'h74;
            3'd3:    ch = 8'h61;
            3'd4:    ch = 8'h72;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // Input register.
    logic                  in_vld_reg;
    logic [7:0]            in_byte_reg;
    logic                  in_take;
    logic                  process;
    logic                  out_space;

    // Parser state.
    logic [8:0]            pos_reg,       pos_next;
    mode_t                 mode_reg,      mode_next;
    logic                  empty_reg,     empty_next;
    logic                  magic_ok_reg,  magic_ok_next;
    logic                  term_reg,      term_next;
    logic [6:0]            name_len_reg,  name_len_next;
    logic [31:0]           tail_reg,      tail_next;
    phase_t                phase_reg,     phase_next;
    logic [SIZE_WIDTH-1:0] acc_reg,       acc_next;
    logic [SIZE_WIDTH-1:0] remain_reg,    remain_next;

    logic                  push;
    tarsu_pkg::result_t    res;
    logic [8:0]            magic_off;
    logic                  is_digit;
    logic                  is_blank;
    logic [7:0]            c;

    assign c         = in_byte_reg;
    assign magic_off = pos_reg - MAGIC_FIRST;
    assign is_digit  = (c >= 8'h30) && (c <= 8'h37);
    assign is_blank  = (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));

    // The parse stage fires whenever it holds a byte and the buffer can take
    // a result, so the input register refills in the same cycle it drains.
    assign process       = in_vld_reg && out_space;
    assign archive.ready = !in_vld_reg || process;
    assign in_take       = archive.valid && archive.ready;

    always_comb
    begin
        pos_next      = pos_reg;
        mode_next     = mode_reg;
        empty_next    = empty_reg;
        magic_ok_next = magic_ok_reg;
        term_next     = term_reg;
        name_len_next = name_len_reg;
        tail_next     = tail_reg;
        phase_next    = phase_reg;
        acc_next      = acc_reg;
        remain_next   = remain_reg;
        push          = 1'b0;
        res           = '{out_kind: tarsu_pkg::KIND_NAME, out_byte: 8'h00,
                          name_pos: 7'd0, file_size: 32'd0, last_of_file: 1'b0};

        if (process && (mode_reg != MODE_ERROR))
        begin
            pos_next = pos_reg + 9'd1;

            if (mode_reg == MODE_HEADER)
            begin
                // Offset zero starts a fresh header.
                if (pos_reg == 9'd0)
                begin
                    empty_next    = 1'b0;
                    magic_ok_next = 1'b1;
                    term_next     = 1'b0;
                    name_len_next = 7'd0;
                    tail_next     = 32'd0;
                    phase_next    = PH_BLANKS;
                    acc_next      = '0;
                end

                if (pos_reg < NAME_BYTES)
                begin
                    if ((pos_reg == 9'd0) && (c == 8'h00))
                    begin
                        empty_next = 1'b1;
                    end
                    if (!term_next)
                    begin
                        if (c == 8'h00)
                        begin
                            term_next = 1'b1;
                        end
                        else
                        begin
                            tail_next     = {tail_next[23:0], c};
                            name_len_next = name_len_next + 7'd1;
                        end
                    end
                    push         = 1'b1;
                    res.out_kind = tarsu_pkg::KIND_NAME;
                    res.out_byte = c;
                    res.name_pos = pos_reg[6:0];
                end
                else if ((pos_reg >= SIZE_FIRST) && (pos_reg <= SIZE_LAST))
                begin
                    case (phase_reg)
                        PH_BLANKS:
                        begin
                            if (is_digit)
                            begin
                                acc_next   = SIZE_WIDTH'(c[2:0]);
                                phase_next = PH_DIGITS;
                            end
                            else if (!is_blank)
                            begin
                                phase_next = PH_DONE;
                            end
                        end
                        PH_DIGITS:
                        begin
                            if (is_digit)
                            begin
                                acc_next = {acc_reg[SIZE_WIDTH-4:0], c[2:0]};
                            end
                            else
                            begin
                                phase_next = PH_DONE;
                            end
                        end
                        default:
                        begin
                            phase_next = phase_reg;
                        end
                    endcase
                end
                else if ((pos_reg >= MAGIC_FIRST) && (pos_reg <= MAGIC_LAST))
                begin
                    if (c != magic_char(magic_off[2:0]))
                    begin
                        magic_ok_next = 1'b0;
                    end
                end
                else if (pos_reg == LAST_POS)
                begin
                    // Verdict priority: end block, bad magic, nested archive.
                    push = 1'b1;
                    if (empty_reg)
                    begin
                        res.out_kind = tarsu_pkg::KIND_END;
                    end
                    else if (!magic_ok_reg)
                    begin
                        res.out_kind = tarsu_pkg::KIND_BAD_MAGIC;
                        mode_next    = MODE_ERROR;
                    end
                    else if ((name_len_reg >= 7'd4) && (tail_reg == TAR_SUFFIX))
                    begin
                        res.out_kind = tarsu_pkg::KIND_NESTED;
                    end
                    else
                    begin
                        res.out_kind  = tarsu_pkg::KIND_ACCEPT;
                        res.file_size = acc_reg[31:0];
                        remain_next   = acc_reg;
                        // An empty file goes straight on to the next header.
                        if (acc_reg != '0)
                        begin
                            mode_next = MODE_FILE;
                        end
                    end
                end
            end
            else
            begin
                if (remain_reg != '0)
                begin
                    push             = 1'b1;
                    res.out_kind     = tarsu_pkg::KIND_DATA;
                    res.out_byte     = c;
                    res.last_of_file = remain_reg == SIZE_WIDTH'(1);
                    remain_next      = remain_reg - SIZE_WIDTH'(1);
                end
                if ((pos_reg == LAST_POS) && (remain_next == '0))
                begin
                    mode_next = MODE_HEADER;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg   <= 1'b0;
            pos_reg      <= 9'd0;
            mode_reg     <= MODE_HEADER;
            empty_reg    <= 1'b0;
            magic_ok_reg <= 1'b1;
            term_reg     <= 1'b0;
            name_len_reg <= 7'd0;
            tail_reg     <= 32'd0;
            phase_reg    <= PH_BLANKS;
            acc_reg      <= '0;
            remain_reg   <= '0;
        end
        else
        begin
            in_vld_reg   <= in_take || (in_vld_reg && !process);
            pos_reg      <= pos_next;
            mode_reg     <= mode_next;
            empty_reg    <= empty_next;
            magic_ok_reg <= magic_ok_next;
            term_reg     <= term_next;
            name_len_reg <= name_len_next;
            tail_reg     <= tail_next;
            phase_reg    <= phase_next;
            acc_reg      <= acc_next;
            remain_reg   <= remain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_byte_reg <= archive.in_byte;
        end
    end

    tarsu_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (res),
        .space     (out_space),
        .result    (result)
    );

    // The error state is sticky until reset.
    `TSU_ASSERT_NEXT(a_error_sticky, clk, rst_n, mode_reg == MODE_ERROR, mode_reg == MODE_ERROR)
    // A pending byte count exists only while a file body is being passed.
    `TSU_ASSERT_SAME(a_remain_in_file, clk, rst_n, remain_reg != '0, mode_reg == MODE_FILE)
    // The name length never passes the width of the name field.
    `TSU_ASSERT_SAME(a_name_len_max, clk, rst_n, 1'b1, name_len_reg <= NAME_MAX)
    // Data transfers are produced only in file mode.
    `TSU_ASSERT_SAME(a_data_in_file, clk, rst_n, push && (res.out_kind == tarsu_pkg::KIND_DATA),
                     mode_reg == MODE_FILE)

endmodule

`default_nettype wire
